>>> rtl/dfcf_pkg.sv
package dfcf_pkg;

	localparam int MAX_RUN = 13;
	localparam int RUN_CNT_W = 4;

	typedef enum logic [2:0] {
		OP_ERASE_PAGE  = 3'd0,
		OP_ERASE_CHIP  = 3'd1,
		OP_READ_START  = 3'd2,
		OP_READ_BYTE   = 3'd3,
		OP_WRITE_START = 3'd4,
		OP_WRITE_BYTE  = 3'd5,
		OP_STATUS      = 3'd6
	} dfcf_op_t;

	localparam logic [2:0] OPCODE_MAX = 3'd6;

	localparam logic [7:0] ERASE_PAGE_CMD = 8'h81;
	localparam logic [7:0] ERASE_CHIP_CMD = 8'hC7;
	localparam logic [23:0] CHIP_ERASE_TAIL = 24'h94809A;
	localparam logic [7:0] CMD_READ = 8'h03;
	localparam logic [7:0] READ_DUMMY = 8'hFF;
	localparam logic [7:0] CMD_PAGE_TO_BUF = 8'h53;
	localparam logic [7:0] CMD_PROG_BUF = 8'h82;
	localparam logic [7:0] CMD_REWRITE = 8'h58;
	localparam logic [7:0] CMD_STATUS = 8'hD7;
	localparam logic [7:0] STATUS_PAD = 8'h00;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [20:0] address;
		logic [7:0]  data_byte;
		logic        last_item;
	} dfcf_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       wait_ready;
		logic       end_frame;
	} dfcf_ent_t;

	typedef struct packed {
		dfcf_ent_t [MAX_RUN-1:0] ent;
		logic [RUN_CNT_W-1:0]    count;
	} dfcf_run_t;

endpackage

>>> rtl/dfcf_if.sv
interface dfcf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [20:0] address;
	logic [7:0]  data_byte;
	logic        last_item;

	modport source (output valid, opcode, address, data_byte, last_item, input ready);
	modport sink (input valid, opcode, address, data_byte, last_item, output ready);
endinterface

interface dfcf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       wait_ready;
	logic       end_frame;
	logic       end_of_run;

	modport source (output valid, tx_byte, wait_ready, end_frame, end_of_run, input ready);
	modport sink (input valid, tx_byte, wait_ready, end_frame, end_of_run, output ready);
endinterface

>>> rtl/dfcf_addr_split.sv
module dfcf_addr_split #(
	parameter int PAGE_BYTES = 512,
	parameter int ADDRESS_BITS = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dfcf_pkg::dfcf_item_t          in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dfcf_pkg::dfcf_item_t          out_item,
	output logic [ADDRESS_BITS-1:0]       out_addr,
	output logic [ADDRESS_BITS-1:0]       out_page,
	output logic [$clog2(PAGE_BYTES)-1:0] out_off
);

	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int DIV_SHIFT = ADDRESS_BITS + OFF_W;
	localparam longint DIV_MULT =
		((longint'(1) << DIV_SHIFT) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
	localparam int MULT_W = $clog2(DIV_MULT + 1);
	localparam int PROD_W = ADDRESS_BITS + MULT_W;

	logic                     v_s1;
	dfcf_pkg::dfcf_item_t     item_s1;
	logic [ADDRESS_BITS-1:0]  addr_s1;
	logic [ADDRESS_BITS-1:0]  page_s1;
	logic                     v_s2;
	dfcf_pkg::dfcf_item_t     item_s2;
	logic [ADDRESS_BITS-1:0]  addr_s2;
	logic [ADDRESS_BITS-1:0]  page_s2;
	logic [OFF_W-1:0]         off_s2;

	logic [ADDRESS_BITS-1:0]  addr_in;
	logic [PROD_W-1:0]        prod;
	logic [ADDRESS_BITS-1:0]  page_base;
	logic                     adv_s2;
	logic                     fire_in;

	// page = floor(a * M / 2^k) is exact for every address of ADDRESS_BITS bits
	assign addr_in = ADDRESS_BITS'(in_item.address);
	assign prod = PROD_W'(addr_in) * PROD_W'(DIV_MULT);
	assign page_base = ADDRESS_BITS'(page_s1 * ADDRESS_BITS'(PAGE_BYTES));

	assign adv_s2 = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;
	assign fire_in = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (fire_in) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			item_s1 <= in_item;
			addr_s1 <= addr_in;
			page_s1 <= ADDRESS_BITS'(prod >> DIV_SHIFT);
		end
		if (adv_s2 && v_s1) begin
			item_s2 <= item_s1;
			addr_s2 <= addr_s1;
			page_s2 <= page_s1;
			off_s2 <= OFF_W'(addr_s1 - page_base);
		end
	end

	assign out_valid = v_s2;
	assign out_item = item_s2;
	assign out_addr = addr_s2;
	assign out_page = page_s2;
	assign out_off = off_s2;

endmodule

>>> rtl/dfcf_frame_gen.sv
module dfcf_frame_gen #(
	parameter int PAGE_BYTES = 512,
	parameter int ADDRESS_BITS = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  dfcf_pkg::dfcf_item_t          item,
	input  logic [ADDRESS_BITS-1:0]       addr,
	input  logic [ADDRESS_BITS-1:0]       page,
	input  logic [$clog2(PAGE_BYTES)-1:0] off,
	input  logic                          can_load,
	output logic                          load,
	output dfcf_pkg::dfcf_run_t           run
);

	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int CODE_W = ADDRESS_BITS + 1;

	logic                    page_mode_q;
	logic [ADDRESS_BITS-1:0] wa_q;
	logic [ADDRESS_BITS-1:0] wpage_q;
	logic [OFF_W-1:0]        woff_q;
	logic                    open_q;
	logic [CODE_W-1:0]       open_code_q;

	logic [ADDRESS_BITS-1:0] wa_nx;
	logic [ADDRESS_BITS-1:0] wpage_nx;
	logic [OFF_W-1:0]        woff_nx;
	logic                    open_nx;
	logic [CODE_W-1:0]       open_code_nx;

	logic [dfcf_pkg::RUN_CNT_W-1:0] n;
	logic                    boundary;
	logic                    wrap_all;
	logic                    page_end;
	logic [CODE_W-1:0]       wcode;
	logic [CODE_W-1:0]       code_cur;

	function automatic logic [CODE_W-1:0] dev_code(input logic mode,
			input logic [ADDRESS_BITS-1:0] pg, input logic [OFF_W-1:0] ofs);
		logic [CODE_W-1:0] shifted;
		if (mode) begin
			shifted = CODE_W'(pg) << OFF_W;
		end else begin
			shifted = CODE_W'(pg) << (OFF_W + 1);
		end
		return shifted | CODE_W'(ofs);
	endfunction

	function automatic dfcf_pkg::dfcf_ent_t frame_byte(input logic [7:0] cmd,
			input logic [23:0] code, input logic w, input logic e, input logic [1:0] k);
		dfcf_pkg::dfcf_ent_t ent;
		ent.wait_ready = 1'b0;
		ent.end_frame = 1'b0;
		case (k)
			2'd0: begin
				ent.tx_byte = cmd;
				ent.wait_ready = w;
			end
			2'd1: ent.tx_byte = code[23:16];
			2'd2: ent.tx_byte = code[15:8];
			default: begin
				ent.tx_byte = code[7:0];
				ent.end_frame = e;
			end
		endcase
		return ent;
	endfunction

	assign item_ready = can_load;
	assign load = item_valid && can_load;

	assign wrap_all = (wa_q == '1);
	assign page_end = (woff_q == OFF_W'(PAGE_BYTES - 1));
	assign boundary = wrap_all || page_end;
	assign wcode = dev_code(page_mode_q, wpage_q, '0);

	always_comb begin
		run = '0;
		n = '0;
		wa_nx = wa_q;
		wpage_nx = wpage_q;
		woff_nx = woff_q;
		open_nx = open_q;
		open_code_nx = open_code_q;
		code_cur = open_code_q;
		if (load && item.opcode <= dfcf_pkg::OPCODE_MAX) begin
			// close the open program frame before any other request
			if (open_q && item.opcode != dfcf_pkg::OP_WRITE_BYTE) begin
				for (int k = 0; k < 4; k++) begin
					run.ent[n] = frame_byte(dfcf_pkg::CMD_REWRITE, 24'(open_code_q),
						1'b1, 1'b1, 2'(k));
					n = n + 1'b1;
				end
				open_nx = 1'b0;
			end
			case (dfcf_pkg::dfcf_op_t'(item.opcode))
				dfcf_pkg::OP_ERASE_PAGE: begin
					for (int k = 0; k < 4; k++) begin
						run.ent[n] = frame_byte(dfcf_pkg::ERASE_PAGE_CMD,
							24'(dev_code(page_mode_q, page, '0)), 1'b0, 1'b1, 2'(k));
						n = n + 1'b1;
					end
				end
				dfcf_pkg::OP_ERASE_CHIP: begin
					for (int k = 0; k < 4; k++) begin
						run.ent[n] = frame_byte(dfcf_pkg::ERASE_CHIP_CMD,
							dfcf_pkg::CHIP_ERASE_TAIL, 1'b0, 1'b1, 2'(k));
						n = n + 1'b1;
					end
				end
				dfcf_pkg::OP_READ_START: begin
					for (int k = 0; k < 4; k++) begin
						run.ent[n] = frame_byte(dfcf_pkg::CMD_READ,
							24'(dev_code(page_mode_q, page, off)), 1'b1, 1'b0, 2'(k));
						n = n + 1'b1;
					end
				end
				dfcf_pkg::OP_READ_BYTE: begin
					run.ent[n] = '{tx_byte: dfcf_pkg::READ_DUMMY, wait_ready: 1'b0,
						end_frame: item.last_item};
					n = n + 1'b1;
				end
				dfcf_pkg::OP_WRITE_START: begin
					wa_nx = addr;
					wpage_nx = page;
					woff_nx = off;
				end
				dfcf_pkg::OP_WRITE_BYTE: begin
					if (!open_q) begin
						code_cur = wcode;
						open_code_nx = wcode;
						for (int k = 0; k < 4; k++) begin
							run.ent[n] = frame_byte(dfcf_pkg::CMD_PAGE_TO_BUF, 24'(wcode),
								1'b1, 1'b1, 2'(k));
							n = n + 1'b1;
						end
						for (int k = 0; k < 4; k++) begin
							run.ent[n] = frame_byte(dfcf_pkg::CMD_PROG_BUF,
								24'(dev_code(page_mode_q, wpage_q, woff_q)), 1'b1, 1'b0, 2'(k));
							n = n + 1'b1;
						end
					end
					// advance the write pointer, wrapping at the address space
					if (wrap_all) begin
						wa_nx = '0;
						wpage_nx = '0;
						woff_nx = '0;
					end else if (page_end) begin
						wa_nx = wa_q + 1'b1;
						wpage_nx = wpage_q + 1'b1;
						woff_nx = '0;
					end else begin
						wa_nx = wa_q + 1'b1;
						woff_nx = woff_q + 1'b1;
					end
					run.ent[n] = '{tx_byte: item.data_byte, wait_ready: 1'b0,
						end_frame: boundary || item.last_item};
					n = n + 1'b1;
					if (boundary || item.last_item) begin
						for (int k = 0; k < 4; k++) begin
							run.ent[n] = frame_byte(dfcf_pkg::CMD_REWRITE, 24'(code_cur),
								1'b1, 1'b1, 2'(k));
							n = n + 1'b1;
						end
						open_nx = 1'b0;
					end else begin
						open_nx = 1'b1;
					end
				end
				dfcf_pkg::OP_STATUS: begin
					run.ent[n] = '{tx_byte: dfcf_pkg::CMD_STATUS, wait_ready: 1'b0,
						end_frame: 1'b0};
					n = n + 1'b1;
					run.ent[n] = '{tx_byte: dfcf_pkg::STATUS_PAD, wait_ready: 1'b0,
						end_frame: 1'b1};
					n = n + 1'b1;
				end
				default: begin
				end
			endcase
		end
		run.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_mode_q <= 1'b0;
			wa_q <= '0;
			wpage_q <= '0;
			woff_q <= '0;
			open_q <= 1'b0;
			open_code_q <= '0;
		end else begin
			if (cfg_we) begin
				page_mode_q <= cfg_wdata;
			end
			wa_q <= wa_nx;
			wpage_q <= wpage_nx;
			woff_q <= woff_nx;
			open_q <= open_nx;
			open_code_q <= open_code_nx;
		end
	end

endmodule

>>> rtl/dfcf_run_queue.sv
module dfcf_run_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dfcf_pkg::dfcf_run_t run,
	output logic                can_load,
	dfcf_rsp_if.source          rsp
);

	dfcf_pkg::dfcf_ent_t            ent_q [dfcf_pkg::MAX_RUN];
	logic [dfcf_pkg::RUN_CNT_W-1:0] cnt_q;
	logic                           take;

	assign take = rsp.valid && rsp.ready;
	assign can_load = (cnt_q == '0) || (cnt_q == 1 && rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run.count;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift toward the head so the output always comes from entry zero
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < dfcf_pkg::MAX_RUN; i++) begin
				ent_q[i] <= run.ent[i];
			end
		end else if (take) begin
			for (int i = 0; i < dfcf_pkg::MAX_RUN - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	assign rsp.valid = (cnt_q != '0);
	assign rsp.tx_byte = ent_q[0].tx_byte;
	assign rsp.wait_ready = ent_q[0].wait_ready;
	assign rsp.end_frame = ent_q[0].end_frame;
	assign rsp.end_of_run = (cnt_q == 1);

endmodule

>>> rtl/dataflash_command_framer_top.sv
// The first result of an accepted item passes address stages s1 and s2, then the run queue.
// Throughput: one item per cycle enters the two-stage address pipeline unless stalled; an item
// yielding N result bytes (N is 0 to 13) holds the result queue until all are taken, one byte
// a cycle while rsp.ready is high. The next run loads in the same cycle as the last byte of
// the current run is taken. Reset (arst_n low) clears the pipeline valids, the queue count, the
// page mode and the write pointer and open-page state at once.
module dataflash_command_framer_top #(
	parameter int PAGE_BYTES = 512,
	parameter int ADDRESS_BITS = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	dfcf_req_if.sink   req,
	dfcf_rsp_if.source rsp
);

	localparam int OFF_W = $clog2(PAGE_BYTES);

	dfcf_pkg::dfcf_item_t    req_item;
	dfcf_pkg::dfcf_item_t    item_s2;
	logic                    v_s2;
	logic                    gen_ready;
	logic [ADDRESS_BITS-1:0] addr_s2;
	logic [ADDRESS_BITS-1:0] page_s2;
	logic [OFF_W-1:0]        off_s2;
	logic                    can_load;
	logic                    load;
	dfcf_pkg::dfcf_run_t     run;

	assign req_item = '{opcode: req.opcode, address: req.address,
		data_byte: req.data_byte, last_item: req.last_item};

	dfcf_addr_split #(
		.PAGE_BYTES(PAGE_BYTES),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_split (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.in_item(req_item),
		.out_valid(v_s2),
		.out_ready(gen_ready),
		.out_item(item_s2),
		.out_addr(addr_s2),
		.out_page(page_s2),
		.out_off(off_s2)
	);

	dfcf_frame_gen #(
		.PAGE_BYTES(PAGE_BYTES),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_gen (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(v_s2),
		.item_ready(gen_ready),
		.item(item_s2),
		.addr(addr_s2),
		.page(page_s2),
		.off(off_s2),
		.can_load(can_load),
		.load(load),
		.run(run)
	);

	dfcf_run_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.run(run),
		.can_load(can_load),
		.rsp(rsp)
	);

endmodule

>>> rtl/dfcf_checker.sv
module dfcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_tx_byte,
	input logic       out_wait_ready,
	input logic       out_end_frame,
	input logic       out_end_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_tx_byte)
			&& $stable(out_end_of_run)))
		else $error("stalled result item changed");

	a_wait_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_wait_ready) |-> (!out_end_frame && !out_end_of_run))
		else $error("busy wait on a byte that closes a frame or run");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_end_of_run) |=> out_valid)
		else $error("gap inside a run");

	a_cmd_then_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_wait_ready) |=>
			(out_valid && !out_wait_ready && !out_end_of_run))
		else $error("command byte not followed by its address byte");

endmodule

bind dataflash_command_framer_top dfcf_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_tx_byte(rsp.tx_byte),
	.out_wait_ready(rsp.wait_ready),
	.out_end_frame(rsp.end_frame),
	.out_end_of_run(rsp.end_of_run)
);

>>> bench/tb_dataflash_command_framer_top.sv
`timescale 1ns / 100ps

module tb_dataflash_command_framer_top;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 50;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       wait_ready;
		logic       end_frame;
		logic       end_of_run;
	} frame_byte_t;

	typedef struct {
		bit                   mode;
		dfcf_pkg::dfcf_item_t it;
		int                   nfix;
		frame_byte_t [3:0]    fix;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dfcf_req_if req_ch ();
	dfcf_rsp_if rsp_ch ();

	dataflash_command_framer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// flash model state
	bit          mode_512;
	logic [20:0] wr_addr;
	bit          page_open;
	logic [21:0] open_code;

	frame_byte_t run_bytes[$];
	frame_byte_t tx_expected[$];
	dir_row_t    dir_rows[$];

	int  errors;
	int  rsp_seen;
	bit  hold_rsp;
	bit  snd_quiet;
	bit  rcv_quiet;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic frame_byte_t fb(logic [7:0] b, logic w, logic e, logic r);
		return '{b, w, e, r};
	endfunction

	function automatic dfcf_pkg::dfcf_item_t mk_item(logic [2:0] op, logic [20:0] addr,
			logic [7:0] data, logic lst);
		return '{op, addr, data, lst};
	endfunction

	function automatic void add_row(bit m, logic [2:0] op, logic [20:0] addr, logic [7:0] data,
			logic lst, int nfix, frame_byte_t f0 = '0, frame_byte_t f1 = '0,
			frame_byte_t f2 = '0, frame_byte_t f3 = '0);
		dir_row_t row;
		row.mode = m;
		row.it = mk_item(op, addr, data, lst);
		row.nfix = nfix;
		row.fix = {f3, f2, f1, f0};
		dir_rows.push_back(row);
	endfunction

	// device address: extended pages carry one extra offset bit
	function automatic logic [21:0] flash_addr(logic [20:0] a, bit with_off);
		logic [8:0] off;
		off = with_off ? a[8:0] : 9'd0;
		if (mode_512) begin
			return {1'b0, a[20:9], off};
		end else begin
			return {a[20:9], 1'b0, off};
		end
	endfunction

	function automatic void put_byte(logic [7:0] b, logic w, logic e);
		run_bytes.push_back('{b, w, e, 1'b0});
	endfunction

	function automatic void put_frame(logic [7:0] cmd, logic [21:0] code, logic w, logic e);
		put_byte(cmd, w, 1'b0);
		put_byte({2'b00, code[21:16]}, 1'b0, 1'b0);
		put_byte(code[15:8], 1'b0, 1'b0);
		put_byte(code[7:0], 1'b0, e);
	endfunction

	function automatic void frame_request(dfcf_pkg::dfcf_item_t it);
		run_bytes.delete();
		if (it.opcode == OP_UNUSED) begin
			return;
		end
		// any request but a write byte or an unused opcode flushes the open page first
		if (it.opcode != dfcf_pkg::OP_WRITE_BYTE && page_open) begin
			put_frame(dfcf_pkg::CMD_REWRITE, open_code, 1'b1, 1'b1);
			page_open = 1'b0;
		end
		case (it.opcode)
			dfcf_pkg::OP_ERASE_PAGE: put_frame(dfcf_pkg::ERASE_PAGE_CMD,
				flash_addr(it.address, 1'b0), 1'b0, 1'b1);
			dfcf_pkg::OP_ERASE_CHIP: begin
				put_byte(dfcf_pkg::ERASE_CHIP_CMD, 1'b0, 1'b0);
				put_byte(dfcf_pkg::CHIP_ERASE_TAIL[23:16], 1'b0, 1'b0);
				put_byte(dfcf_pkg::CHIP_ERASE_TAIL[15:8], 1'b0, 1'b0);
				put_byte(dfcf_pkg::CHIP_ERASE_TAIL[7:0], 1'b0, 1'b1);
			end
			dfcf_pkg::OP_READ_START: put_frame(dfcf_pkg::CMD_READ,
				flash_addr(it.address, 1'b1), 1'b1, 1'b0);
			dfcf_pkg::OP_READ_BYTE: put_byte(dfcf_pkg::READ_DUMMY, 1'b0, it.last_item);
			dfcf_pkg::OP_WRITE_START: wr_addr = it.address;
			dfcf_pkg::OP_WRITE_BYTE: begin
				if (!page_open) begin
					open_code = flash_addr(wr_addr, 1'b0);
					put_frame(dfcf_pkg::CMD_PAGE_TO_BUF, open_code, 1'b1, 1'b1);
					put_frame(dfcf_pkg::CMD_PROG_BUF, flash_addr(wr_addr, 1'b1), 1'b1, 1'b0);
					page_open = 1'b1;
				end
				wr_addr = wr_addr + 21'd1;
				if (wr_addr[8:0] == 9'd0 || it.last_item) begin
					put_byte(it.data_byte, 1'b0, 1'b1);
					put_frame(dfcf_pkg::CMD_REWRITE, open_code, 1'b1, 1'b1);
					page_open = 1'b0;
				end else begin
					put_byte(it.data_byte, 1'b0, 1'b0);
				end
			end
			default: begin
				put_byte(dfcf_pkg::CMD_STATUS, 1'b0, 1'b0);
				put_byte(dfcf_pkg::STATUS_PAD, 1'b0, 1'b1);
			end
		endcase
		if (run_bytes.size() > 0) begin
			run_bytes[run_bytes.size() - 1].end_of_run = 1'b1;
		end
	endfunction

	function automatic logic [20:0] pick_addr();
		case ($urandom_range(0, 3))
			0: return 21'($urandom);
			1: return {12'($urandom), 9'(511 - $urandom_range(0, 6))};
			2: return 21'h1FFFFF - 21'($urandom_range(0, 4));
			default: return {12'($urandom), 9'd0};
		endcase
	endfunction

	// nfix < 0: take the predicted run; otherwise the typed bytes
	task automatic send_item(dfcf_pkg::dfcf_item_t it, int nfix, frame_byte_t [3:0] fix);
		int gap;
		if ($urandom_range(0, 15) == 0) begin
			snd_quiet = !snd_quiet;
		end
		gap = snd_quiet ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= it.opcode;
		req_ch.address <= it.address;
		req_ch.data_byte <= it.data_byte;
		req_ch.last_item <= it.last_item;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		frame_request(it);
		if (nfix < 0) begin
			foreach (run_bytes[i]) begin
				tx_expected.push_back(run_bytes[i]);
			end
		end else begin
			for (int i = 0; i < nfix; i++) begin
				tx_expected.push_back(fix[i]);
			end
		end
	endtask

	// let the last item leave the pipeline even if it made no bytes
	task automatic drain();
		int n;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		n = 0;
		while (tx_expected.size() != 0 && n < 20000) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(bit m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_512 = m;
	endtask

	task automatic run_random_phase(int phase, int target);
		int done_items;
		int n;
		bit lst;
		logic [2:0] op;
		done_items = 0;
		while (done_items < target) begin
			if (phase == 0 && done_items >= 12 && !hold_rsp) begin
				hold_rsp = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(1, 24);
					lst = ($urandom_range(0, 4) != 0);
					send_item(mk_item(dfcf_pkg::OP_WRITE_START, pick_addr(), 8'($urandom),
						1'($urandom)), -1, '0);
					done_items++;
					for (int i = 0; i < n; i++) begin
						send_item(mk_item(dfcf_pkg::OP_WRITE_BYTE, 21'($urandom), 8'($urandom),
							(i == n - 1) ? lst : ($urandom_range(0, 15) == 0)), -1, '0);
						done_items++;
					end
				end
				4, 5: begin
					n = $urandom_range(1, 8);
					send_item(mk_item(dfcf_pkg::OP_READ_START, pick_addr(), 8'($urandom),
						1'($urandom)), -1, '0);
					done_items++;
					for (int i = 0; i < n; i++) begin
						send_item(mk_item(dfcf_pkg::OP_READ_BYTE, 21'($urandom), 8'($urandom),
							(i == n - 1) ? ($urandom_range(0, 5) != 0) : 1'b0), -1, '0);
						done_items++;
					end
				end
				6: begin
					send_item(mk_item(dfcf_pkg::OP_ERASE_PAGE, pick_addr(), 8'($urandom),
						1'($urandom)), -1, '0);
					done_items++;
				end
				7: begin
					op = $urandom_range(0, 1) ? dfcf_pkg::OP_ERASE_CHIP : dfcf_pkg::OP_STATUS;
					send_item(mk_item(op, 21'($urandom), 8'($urandom), 1'($urandom)), -1, '0);
					done_items++;
				end
				8: begin
					op = 3'($urandom_range(0, 7));
					send_item(mk_item(op, 21'($urandom), 8'($urandom), 1'($urandom)), -1, '0);
					if (op != OP_UNUSED) begin
						done_items++;
					end
				end
				default: begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++) begin
						send_item(mk_item(dfcf_pkg::OP_WRITE_BYTE, 21'($urandom), 8'($urandom),
							$urandom_range(0, 3) == 0), -1, '0);
						done_items++;
					end
				end
			endcase
		end
	endtask

	initial begin
		int gap;
		bit hold_taken;
		frame_byte_t got;
		frame_byte_t want;
		rsp_ch.ready = 1'b0;
		rcv_quiet = 1'b0;
		errors = 0;
		rsp_seen = 0;
		hold_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_taken) begin
				hold_taken = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				if ($urandom_range(0, 15) == 0) begin
					rcv_quiet = !rcv_quiet;
				end
				gap = rcv_quiet ? 0 : $urandom_range(0, 5);
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got = '{rsp_ch.tx_byte, rsp_ch.wait_ready, rsp_ch.end_frame, rsp_ch.end_of_run};
			if (tx_expected.size() == 0) begin
				note_error($sformatf("result %0d: unexpected tx %02h wait %0b end %0b run %0b",
					rsp_seen, got.tx_byte, got.wait_ready, got.end_frame, got.end_of_run));
			end else begin
				want = tx_expected.pop_front();
				if (got !== want) begin
					note_error($sformatf({"result %0d: expected tx %02h wait %0b end %0b run %0b,",
						" got tx %02h wait %0b end %0b run %0b"}, rsp_seen,
						want.tx_byte, want.wait_ready, want.end_frame, want.end_of_run,
						got.tx_byte, got.wait_ready, got.end_frame, got.end_of_run));
				end
			end
			rsp_seen++;
		end
	end

	initial begin
		int cur_mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = dfcf_pkg::OP_ERASE_PAGE;
		req_ch.address = '0;
		req_ch.data_byte = '0;
		req_ch.last_item = 1'b0;
		mode_512 = 1'b0;
		wr_addr = '0;
		page_open = 1'b0;
		open_code = '0;
		hold_rsp = 1'b0;
		snd_quiet = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extended pages
		add_row(1'b0, dfcf_pkg::OP_STATUS, 21'h0, 8'h00, 1'b0, 2,
			fb(dfcf_pkg::CMD_STATUS, 0, 0, 0), fb(dfcf_pkg::STATUS_PAD, 0, 1, 1));
		add_row(1'b0, dfcf_pkg::OP_ERASE_CHIP, 21'h1FFFFF, 8'hFF, 1'b1, 4,
			fb(dfcf_pkg::ERASE_CHIP_CMD, 0, 0, 0), fb(dfcf_pkg::CHIP_ERASE_TAIL[23:16], 0, 0, 0),
			fb(dfcf_pkg::CHIP_ERASE_TAIL[15:8], 0, 0, 0),
			fb(dfcf_pkg::CHIP_ERASE_TAIL[7:0], 0, 1, 1));
		// dummy read with no read start before it
		add_row(1'b0, dfcf_pkg::OP_READ_BYTE, 21'h0, 8'h00, 1'b1, 1,
			fb(dfcf_pkg::READ_DUMMY, 0, 1, 1));
		add_row(1'b0, dfcf_pkg::OP_ERASE_PAGE, 21'h0, 8'h00, 1'b0, 4,
			fb(dfcf_pkg::ERASE_PAGE_CMD, 0, 0, 0), fb(8'h00, 0, 0, 0), fb(8'h00, 0, 0, 0),
			fb(8'h00, 0, 1, 1));
		add_row(1'b0, dfcf_pkg::OP_ERASE_PAGE, 21'h1FFFFF, 8'hFF, 1'b1, 4,
			fb(dfcf_pkg::ERASE_PAGE_CMD, 0, 0, 0), fb(8'h3F, 0, 0, 0), fb(8'hFC, 0, 0, 0),
			fb(8'h00, 0, 1, 1));
		add_row(1'b0, dfcf_pkg::OP_READ_START, 21'h1FFFFF, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_READ_BYTE, 21'h0, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_READ_BYTE, 21'h0, 8'h00, 1'b1, -1);
		// write across the top of the address space: wrap closes the page
		add_row(1'b0, dfcf_pkg::OP_WRITE_START, 21'h1FFFFE, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'hFF, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'hA5, 1'b1, -1);
		// page left open, flushed by other requests
		add_row(1'b0, dfcf_pkg::OP_WRITE_START, 21'h12345, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'h5A, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_STATUS, 21'h0, 8'h00, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'hC3, 1'b0, -1);
		add_row(1'b0, dfcf_pkg::OP_ERASE_CHIP, 21'h0, 8'h00, 1'b0, -1);
		add_row(1'b0, OP_UNUSED, 21'h1FFFFF, 8'hFF, 1'b1, 0);
		// binary pages
		add_row(1'b1, dfcf_pkg::OP_ERASE_PAGE, 21'h1FFFFF, 8'h00, 1'b0, 4,
			fb(dfcf_pkg::ERASE_PAGE_CMD, 0, 0, 0), fb(8'h1F, 0, 0, 0), fb(8'hFE, 0, 0, 0),
			fb(8'h00, 0, 1, 1));
		add_row(1'b1, dfcf_pkg::OP_READ_START, 21'h0ABCDE, 8'h00, 1'b0, -1);
		add_row(1'b1, dfcf_pkg::OP_READ_BYTE, 21'h0, 8'h00, 1'b1, -1);
		add_row(1'b1, dfcf_pkg::OP_WRITE_START, 21'h0001FF, 8'h00, 1'b0, -1);
		add_row(1'b1, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'h11, 1'b0, -1);
		add_row(1'b1, dfcf_pkg::OP_WRITE_BYTE, 21'h0, 8'h3C, 1'b1, -1);
		add_row(1'b1, OP_UNUSED, 21'h0, 8'h00, 1'b0, -1);

		cur_mode = -1;
		foreach (dir_rows[i]) begin
			if (int'(dir_rows[i].mode) != cur_mode) begin
				drain();
				set_mode(dir_rows[i].mode);
				cur_mode = int'(dir_rows[i].mode);
			end
			send_item(dir_rows[i].it, dir_rows[i].nfix, dir_rows[i].fix);
		end

		for (int p = 0; p < 6; p++) begin
			drain();
			set_mode(p % 2 == 0);
			run_random_phase(p, PHASE_ITEMS);
		end

		drain();
		@(negedge clk);
		if (tx_expected.size() != 0) begin
			$display("%0d expected results never arrived", tx_expected.size());
		end
		if (errors == 0 && tx_expected.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/dfcf_pkg.sv
rtl/dfcf_if.sv
rtl/dfcf_addr_split.sv
rtl/dfcf_frame_gen.sv
rtl/dfcf_run_queue.sv
rtl/dataflash_command_framer_top.sv
rtl/dfcf_checker.sv
bench/tb_dataflash_command_framer_top.sv
